// ----- rtl/afc_pkg.sv -----
// Shared constants and word types for the AABB frustum cull test pipeline.
// No dependencies; every other file in this folder but afc_check imports this package.
`default_nettype none

package afc_pkg;

    localparam int COORD_BITS  = 16;
    localparam int COEF_BITS   = 16;
    localparam int LANE_BITS   = 16;
    localparam int ROW_BITS    = 4 * LANE_BITS;
    localparam int HALF_BITS   = COORD_BITS - 1;
    localparam int PROD_BITS   = COEF_BITS + COORD_BITS;
    localparam int CSUM_BITS   = PROD_BITS + 2;
    localparam int CORNER_BITS = CSUM_BITS + 2;
    localparam int TEST_BITS   = CORNER_BITS + 1;
    localparam int ROWS        = 4;
    localparam int AXES        = 3;
    localparam int CORNERS     = 8;
    localparam int PLANES      = 6;

    localparam int ROW_X = 0;
    localparam int ROW_Y = 1;
    localparam int ROW_Z = 2;
    localparam int ROW_W = 3;

    typedef struct packed {
        logic [ROW_BITS-1:0]          row_x;
        logic [ROW_BITS-1:0]          row_y;
        logic [ROW_BITS-1:0]          row_z;
        logic [ROW_BITS-1:0]          row_w;
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic signed [COORD_BITS-1:0] center_z;
        logic [HALF_BITS-1:0]         half_x;
        logic [HALF_BITS-1:0]         half_y;
        logic [HALF_BITS-1:0]         half_z;
    } box_t;

    typedef struct packed {
        logic [ROWS-1:0][AXES-1:0][PROD_BITS-1:0] cprod;
        logic [ROWS-1:0][AXES-1:0][PROD_BITS-1:0] hprod;
        logic [ROWS-1:0][COEF_BITS-1:0]           offs;
    } mul_t;

    typedef struct packed {
        logic [ROWS-1:0][CSUM_BITS-1:0]           csum;
        logic [ROWS-1:0][AXES-1:0][PROD_BITS-1:0] hprod;
    } sum_t;

    typedef struct packed {
        logic [ROWS-1:0][CORNERS-1:0][CORNER_BITS-1:0] vert;
    } vert_t;

endpackage

`default_nettype wire

// ----- rtl/afc_if.sv -----
// Valid/ready channel interfaces for the box input and the cull result output.
// Depends on afc_pkg for field widths.
`default_nettype none

interface afc_box_if;
    import afc_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [ROW_BITS-1:0]          row_x;
    logic [ROW_BITS-1:0]          row_y;
    logic [ROW_BITS-1:0]          row_z;
    logic [ROW_BITS-1:0]          row_w;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [COORD_BITS-1:0] center_z;
    logic [HALF_BITS-1:0]         half_x;
    logic [HALF_BITS-1:0]         half_y;
    logic [HALF_BITS-1:0]         half_z;

    modport source (
        output valid, row_x, row_y, row_z, row_w,
        output center_x, center_y, center_z, half_x, half_y, half_z,
        input  ready
    );
    modport sink (
        input  valid, row_x, row_y, row_z, row_w,
        input  center_x, center_y, center_z, half_x, half_y, half_z,
        output ready
    );
endinterface

interface afc_res_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (
        output valid, inside_res,
        input  ready
    );
    modport sink (
        input  valid, inside_res,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/afc_mul.sv -----
// First pipeline stage: all coefficient products with the box center and half-widths.
// Depends on afc_pkg.
`default_nettype none

module afc_mul (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          box_valid,
    output logic          box_ready,
    input  afc_pkg::box_t box,
    output logic          mul_valid,
    input  logic          mul_ready,
    output afc_pkg::mul_t mul
);
    import afc_pkg::*;

    logic valid_reg;
    mul_t mul_reg;
    mul_t mul_next;

    assign box_ready = !valid_reg || mul_ready;
    assign mul_valid = valid_reg;
    assign mul       = mul_reg;

    always_comb
    begin
        logic [ROW_BITS-1:0]         row [ROWS];
        logic signed [PROD_BITS-1:0] cen_ext [AXES];
        logic signed [PROD_BITS-1:0] half_ext [AXES];
        logic [COEF_BITS-1:0]        coef;
        logic signed [PROD_BITS-1:0] coef_ext;

        row[ROW_X] = box.row_x;
        row[ROW_Y] = box.row_y;
        row[ROW_Z] = box.row_z;
        row[ROW_W] = box.row_w;
        cen_ext[0] = {{(PROD_BITS-COORD_BITS){box.center_x[COORD_BITS-1]}}, box.center_x};
        cen_ext[1] = {{(PROD_BITS-COORD_BITS){box.center_y[COORD_BITS-1]}}, box.center_y};
        cen_ext[2] = {{(PROD_BITS-COORD_BITS){box.center_z[COORD_BITS-1]}}, box.center_z};
        half_ext[0] = {{(PROD_BITS-HALF_BITS){1'b0}}, box.half_x};
        half_ext[1] = {{(PROD_BITS-HALF_BITS){1'b0}}, box.half_y};
        half_ext[2] = {{(PROD_BITS-HALF_BITS){1'b0}}, box.half_z};
        for (int r = 0; r < ROWS; r++)
        begin
            for (int j = 0; j < AXES; j++)
            begin
                coef     = row[r][LANE_BITS*j +: COEF_BITS];
                coef_ext = {{(PROD_BITS-COEF_BITS){coef[COEF_BITS-1]}}, coef};
                mul_next.cprod[r][j] = coef_ext * cen_ext[j];
                mul_next.hprod[r][j] = coef_ext * half_ext[j];
            end
            mul_next.offs[r] = row[r][LANE_BITS*AXES +: COEF_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (box_ready)
        begin
            valid_reg <= box_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (box_valid && box_ready)
        begin
            mul_reg <= mul_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/afc_corner.sv -----
// Second and third pipeline stages: center dot products, then the eight corner values per row.
// Depends on afc_pkg.
`default_nettype none

module afc_corner (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           mul_valid,
    output logic           mul_ready,
    input  afc_pkg::mul_t  mul,
    output logic           vert_valid,
    input  logic           vert_ready,
    output afc_pkg::vert_t vert
);
    import afc_pkg::*;

    logic  sum_valid_reg;
    sum_t  sum_reg;
    sum_t  sum_next;
    logic  sum_ready;
    logic  vert_valid_reg;
    vert_t vert_reg;
    vert_t vert_next;

    assign sum_ready  = !vert_valid_reg || vert_ready;
    assign mul_ready  = !sum_valid_reg || sum_ready;
    assign vert_valid = vert_valid_reg;
    assign vert       = vert_reg;

    always_comb
    begin
        logic signed [CSUM_BITS-1:0] acc;
        logic [PROD_BITS-1:0]        p;
        logic [COEF_BITS-1:0]        o;

        sum_next.hprod = mul.hprod;
        for (int r = 0; r < ROWS; r++)
        begin
            o   = mul.offs[r];
            acc = {{(CSUM_BITS-COEF_BITS){o[COEF_BITS-1]}}, o};
            for (int j = 0; j < AXES; j++)
            begin
                p   = mul.cprod[r][j];
                acc = acc + {{(CSUM_BITS-PROD_BITS){p[PROD_BITS-1]}}, p};
            end
            sum_next.csum[r] = acc;
        end
    end

    always_comb
    begin
        logic signed [CORNER_BITS-1:0] base;
        logic signed [CORNER_BITS-1:0] acc;
        logic signed [CORNER_BITS-1:0] term;
        logic [CSUM_BITS-1:0]          c;
        logic [PROD_BITS-1:0]          h;

        for (int r = 0; r < ROWS; r++)
        begin
            c    = sum_reg.csum[r];
            base = {{(CORNER_BITS-CSUM_BITS){c[CSUM_BITS-1]}}, c};
            for (int k = 0; k < CORNERS; k++)
            begin
                acc = base;
                for (int j = 0; j < AXES; j++)
                begin
                    h    = sum_reg.hprod[r][j];
                    term = {{(CORNER_BITS-PROD_BITS){h[PROD_BITS-1]}}, h};
                    if (((k >> (AXES - 1 - j)) & 1) != 0)
                    begin
                        acc = acc + term;
                    end
                    else
                    begin
                        acc = acc - term;
                    end
                end
                vert_next.vert[r][k] = acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg  <= 1'b0;
            vert_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_ready)
            begin
                sum_valid_reg <= mul_valid;
            end
            if (sum_ready)
            begin
                vert_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_valid && mul_ready)
        begin
            sum_reg <= sum_next;
        end
        if (sum_valid_reg && sum_ready)
        begin
            vert_reg <= vert_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/afc_plane.sv -----
// Last pipeline stage: strict six-plane tests over all corners and the registered result.
// Depends on afc_pkg.
`default_nettype none

module afc_plane (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           vert_valid,
    output logic           vert_ready,
    input  afc_pkg::vert_t vert,
    output logic           res_valid,
    input  logic           res_ready,
    output logic           inside_res
);
    import afc_pkg::*;

    logic res_valid_reg;
    logic inside_reg;
    logic inside_next;

    assign vert_ready = !res_valid_reg || res_ready;
    assign res_valid  = res_valid_reg;
    assign inside_res = inside_reg;

    always_comb
    begin
        logic signed [TEST_BITS-1:0] comp [ROWS];
        logic [CORNER_BITS-1:0]      v;
        logic [PLANES-1:0]           any;

        any = '0;
        for (int k = 0; k < CORNERS; k++)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                v       = vert.vert[r][k];
                comp[r] = {v[CORNER_BITS-1], v};
            end
            for (int a = 0; a < AXES; a++)
            begin
                if (comp[a] + comp[ROW_W] > 0)
                begin
                    any[2*a] = 1'b1;
                end
                if (comp[ROW_W] - comp[a] > 0)
                begin
                    any[2*a+1] = 1'b1;
                end
            end
        end
        inside_next = &any;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (vert_ready)
        begin
            res_valid_reg <= vert_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vert_valid && vert_ready)
        begin
            inside_reg <= inside_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/aabb_frustum_cull_test_top.sv -----
// Top level of the AABB frustum cull test: four pipeline stages behind valid/ready channels.
// Depends on afc_pkg, afc_if, afc_mul, afc_corner and afc_plane.
`default_nettype none

// The block takes one box word per clock while the result side does not stall and returns
// one result word per box, in order, once the box has passed every stage. The first stage
// holds 24 multipliers, one per matrix coefficient and center or half-width term; the second
// adds the center terms and the offset per row; the third forms the eight corner values per
// row; the fourth runs the six strict plane tests on every corner and registers the result.
// Each stage has its own valid bit and takes a new word whenever it is empty or its
// successor moves, so a waiting result does not block stages that still have room.
module aabb_frustum_cull_test_top (
    input  logic  clk,
    input  logic  rst_n,
    afc_box_if.sink   box,
    afc_res_if.source res
);
    import afc_pkg::*;

    box_t  box_word;
    logic  mul_valid;
    logic  mul_ready;
    mul_t  mul;
    logic  vert_valid;
    logic  vert_ready;
    vert_t vert;

    assign box_word.row_x    = box.row_x;
    assign box_word.row_y    = box.row_y;
    assign box_word.row_z    = box.row_z;
    assign box_word.row_w    = box.row_w;
    assign box_word.center_x = box.center_x;
    assign box_word.center_y = box.center_y;
    assign box_word.center_z = box.center_z;
    assign box_word.half_x   = box.half_x;
    assign box_word.half_y   = box.half_y;
    assign box_word.half_z   = box.half_z;

    afc_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .box_valid (box.valid),
        .box_ready (box.ready),
        .box       (box_word),
        .mul_valid (mul_valid),
        .mul_ready (mul_ready),
        .mul       (mul)
    );

    afc_corner u_corner (
        .clk        (clk),
        .rst_n      (rst_n),
        .mul_valid  (mul_valid),
        .mul_ready  (mul_ready),
        .mul        (mul),
        .vert_valid (vert_valid),
        .vert_ready (vert_ready),
        .vert       (vert)
    );

    afc_plane u_plane (
        .clk        (clk),
        .rst_n      (rst_n),
        .vert_valid (vert_valid),
        .vert_ready (vert_ready),
        .vert       (vert),
        .res_valid  (res.valid),
        .res_ready  (res.ready),
        .inside_res (res.inside_res)
    );

endmodule

`default_nettype wire

// ----- rtl/afc_check.sv -----
// Port-level checks on the cull test top level, attached to it by a bind statement.
// Depends on aabb_frustum_cull_test_top and its channel interfaces.
`default_nettype none

module afc_check (
    input logic clk,
    input logic rst_n,
    input logic box_valid,
    input logic box_ready,
    input logic res_valid,
    input logic res_ready
);

    // A result word that is not taken stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word dropped while stalled");

    // With no result waiting, every stage has room.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> box_ready)
        else $error("input blocked with empty output");

    // A sink that takes results lets the whole pipeline move.
    a_flow_ready: assert property (@(posedge clk) disable iff (!rst_n)
        res_ready |-> box_ready)
        else $error("input blocked while output drains");

    // A box taken while the output drains comes out as a valid result after the last stage.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (box_valid && box_ready) ##1 res_ready ##1 res_ready ##1 res_ready |=> res_valid)
        else $error("result word missing after pipeline latency");

endmodule

bind aabb_frustum_cull_test_top afc_check u_afc_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .box_valid (box.valid),
    .box_ready (box.ready),
    .res_valid (res.valid),
    .res_ready (res.ready)
);

`default_nettype wire
